[sv/fdep_pkg.sv]
// ----------------------------------------------------------------------------
// fdep_pkg
// Shared constants, types and tables for the FAT directory entry parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fdep_pkg;

  // Sizing
  localparam int ENTRIES_PER_SECTOR = 16;
  localparam int MAX_LISTED         = 16;
  localparam int LONG_NAME_BYTES    = 64;
  localparam int NAME_CHARS         = 32;

  localparam int ENTRY_BYTES    = 32;
  localparam int ENT_AW         = 5;
  localparam int LFN_CHARS      = 13;
  localparam int SHORT_NAME_LEN = 11;
  localparam int LONG_LIMIT     = (NAME_CHARS < LONG_NAME_BYTES) ? NAME_CHARS
                                                                 : LONG_NAME_BYTES;

  localparam int LN_AW   = $clog2(LONG_NAME_BYTES);
  localparam int SLOT_W  = $clog2(ENTRIES_PER_SECTOR + 1);
  localparam int LIST_W  = $clog2(MAX_LISTED + 1);
  localparam int NIDX_W  = $clog2(NAME_CHARS + 1);
  // long-name write pointer: 13 * 14 + 13 fits in 9 bits
  localparam int LPTR_W  = 9;

  // Directory byte codes
  localparam logic [7:0] DIR_END    = 8'h00;
  localparam logic [7:0] DIR_FREE   = 8'hE5;
  localparam logic [7:0] ATTR_LFN   = 8'h0F;
  localparam int         ATTR_DIR_B = 4;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Entry byte positions
  localparam logic [ENT_AW-1:0] POS_ATTR      = 5'd11;
  localparam logic [ENT_AW-1:0] POS_SIZE_LO   = 5'd28;
  localparam logic [ENT_AW-1:0] POS_LAST      = 5'd31;

  // Write request into the long-name store
  typedef struct packed {
    logic             en;
    logic [LN_AW-1:0] addr;
    logic [7:0]       data;
  } lns_wr_t;

  // Byte offset of long-name character k within a long-name record
  function automatic logic [ENT_AW-1:0] lfn_offset(input logic [3:0] k);
    logic [ENT_AW-1:0] off;
    case (k)
      4'd0:    off = 5'd1;
      4'd1:    off = 5'd3;
      4'd2:    off = 5'd5;
      4'd3:    off = 5'd7;
      4'd4:    off = 5'd9;
      4'd5:    off = 5'd14;
      4'd6:    off = 5'd16;
      4'd7:    off = 5'd18;
      4'd8:    off = 5'd20;
      4'd9:    off = 5'd22;
      4'd10:   off = 5'd24;
      4'd11:   off = 5'd28;
      4'd12:   off = 5'd30;
      default: off = 5'd1;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

[sv/fdep_name_store.sv]
// ----------------------------------------------------------------------------
// fdep_name_store
// Long-name character store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fdep_name_store
  import fdep_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lns_wr_t          wr,
  input  wire logic [LN_AW-1:0] rd_addr,
  output logic [7:0]            rd_data
);

  logic [7:0]                 mem_r [LONG_NAME_BYTES];
  logic [LONG_NAME_BYTES-1:0] vld_r;
  logic [7:0]                 rd_q_r;
  logic                       rd_vld_r;

  // Storage array and read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : CHAR_NUL;

endmodule

`default_nettype wire

[sv/fat_directory_entry_parser_core.sv]
// ----------------------------------------------------------------------------
// fat_directory_entry_parser_core
// Lists FAT directory entries as a stream of name characters.
//
// Usage:
//  - Input: one sector byte per word on in_tdata; in_tuser = 1 on the first
//    byte of a sector restarts the scan. Bytes gather into 32-byte entries.
//  - Output: one word per name character; out_tlast marks the last character
//    of a name; size, slot and listing ordinal ride along in out_tdata and
//    the folder flag in out_tuser.
//  - Throughput: one byte per cycle. After the last byte of a listed entry
//    the input stalls while each name character is read, checked and loaded
//    into the output register, also for an empty name. After a long-name
//    record it stalls while 13 characters are copied into the name store.
//  - Reset: scan active at slot 0, no long name pending, name store zero.
//  - A stalled receiver holds the output register; the name sequencer waits
//    on it and the input stays blocked until the name is fully loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_entry_parser_core
  import fdep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] sector_start
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] name_char, [39:8] size_bytes,
                                       // [43:40] entry_slot, [47:44] listing_index
  output logic             out_tlast,  // last_char
  output logic             out_tuser   // [0] is_folder
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LFN  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CAP  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  // Scan state
  logic [2:0]        state_r, state_nxt;
  logic [ENT_AW-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LIST_W-1:0] listed_r, listed_nxt;
  logic              stop_r, stop_nxt;
  logic              pend_r, pend_nxt;

  // Captured entry fields
  logic [7:0]  b0_r, b0_nxt;
  logic [7:0]  attr_r, attr_nxt;
  logic [31:0] size_r, size_nxt;

  // Long-name copy pass
  logic [3:0]        cp_k_r, cp_k_nxt;
  logic [LPTR_W-1:0] cp_ptr_r, cp_ptr_nxt;
  logic [LPTR_W-1:0] cp_wptr_r, cp_wptr_nxt;
  logic              cp_wv_r, cp_wv_nxt;

  // Name emission
  logic              use_long_r, use_long_nxt;
  logic              first_r, first_nxt;
  logic [NIDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]        cur_r, cur_nxt;
  logic [7:0]        nch_r, nch_nxt;
  logic              nterm_r, nterm_nxt;
  logic [31:0]       lsize_r, lsize_nxt;
  logic [3:0]        lslot_r, lslot_nxt;
  logic [3:0]        llist_r, llist_nxt;
  logic              lfold_r, lfold_nxt;

  // Output register
  logic        ov_r, ov_nxt;
  logic [7:0]  ochar_r, ochar_nxt;
  logic        olast_r, olast_nxt;
  logic [31:0] osize_r, osize_nxt;
  logic [3:0]  oslot_r, oslot_nxt;
  logic [3:0]  olist_r, olist_nxt;
  logic        ofold_r, ofold_nxt;

  // Entry buffer
  logic [7:0]        ent_mem_r [ENTRY_BYTES];
  logic [7:0]        ent_rd_r;
  logic [ENT_AW-1:0] ent_rd_addr;

  // Long-name store interface
  lns_wr_t    ln_wr;
  logic [7:0] ln_rd_data;

  // Misc combinational
  logic       in_acc;
  logic       run;
  logic [7:0] ch;
  logic       term;
  logic       out_free;
  logic [31:0] size_full;

  function automatic logic [ENT_AW-1:0] ent_rd_addr_name(input logic [NIDX_W-1:0] i);
    return ENT_AW'(i);
  endfunction

  function automatic logic [ENT_AW-1:0] pos_nxt_wr(input logic st,
                                                   input logic [ENT_AW-1:0] p);
    return st ? '0 : p;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  // Entry buffer: written from the input, read by the sequencer
  assign ent_rd_addr = (state_r == S_LFN) ? lfn_offset(cp_k_r) : ent_rd_addr_name(idx_r);

  always_ff @(posedge clk) begin
    if (in_acc && run) begin
      ent_mem_r[pos_nxt_wr(in_tuser, pos_r)] <= in_tdata;
    end
    ent_rd_r <= ent_mem_r[ent_rd_addr];
  end

  // Long-name store writes from the copy pass
  always_comb begin
    ln_wr.en   = (state_r == S_LFN) && cp_wv_r && (cp_wptr_r < LPTR_W'(LONG_NAME_BYTES));
    ln_wr.addr = LN_AW'(cp_wptr_r);
    ln_wr.data = ent_rd_r;
  end

  fdep_name_store u_name_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (ln_wr),
    .rd_addr (LN_AW'(idx_r)),
    .rd_data (ln_rd_data)
  );

  // Active scan after an optional restart on this word
  assign run = in_tuser || !stop_r;

  // Character under check and its end condition
  assign ch   = use_long_r ? ln_rd_data : ent_rd_r;
  assign term = (idx_r == (use_long_r ? NIDX_W'(LONG_LIMIT) : NIDX_W'(SHORT_NAME_LEN))) ||
                (ch == CHAR_NUL) || (!use_long_r && (ch == CHAR_SPACE));
  assign size_full = {in_tdata, size_r[31:8]};

  // Next-state logic
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    slot_nxt     = slot_r;
    listed_nxt   = listed_r;
    stop_nxt     = stop_r;
    pend_nxt     = pend_r;
    b0_nxt       = b0_r;
    attr_nxt     = attr_r;
    size_nxt     = size_r;
    cp_k_nxt     = cp_k_r;
    cp_ptr_nxt   = cp_ptr_r;
    cp_wptr_nxt  = cp_wptr_r;
    cp_wv_nxt    = cp_wv_r;
    use_long_nxt = use_long_r;
    first_nxt    = first_r;
    idx_nxt      = idx_r;
    cur_nxt      = cur_r;
    nch_nxt      = nch_r;
    nterm_nxt    = nterm_r;
    lsize_nxt    = lsize_r;
    lslot_nxt    = lslot_r;
    llist_nxt    = llist_r;
    lfold_nxt    = lfold_r;
    ov_nxt       = ov_r;
    ochar_nxt    = ochar_r;
    olast_nxt    = olast_r;
    osize_nxt    = osize_r;
    oslot_nxt    = oslot_r;
    olist_nxt    = olist_r;
    ofold_nxt    = ofold_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // sector restart comes before the byte is taken
          if (in_tuser) begin
            pos_nxt    = '0;
            slot_nxt   = '0;
            listed_nxt = '0;
            stop_nxt   = 1'b0;
            pend_nxt   = 1'b0;
          end
          if (run) begin
            // capture the fields needed at judge time
            if (in_tuser || (pos_r == '0)) begin
              b0_nxt = in_tdata;
            end
            if (!in_tuser && (pos_r == POS_ATTR)) begin
              attr_nxt = in_tdata;
            end
            if (!in_tuser && (pos_r >= POS_SIZE_LO)) begin
              size_nxt = size_full;
            end

            if (in_tuser || (pos_r != POS_LAST)) begin
              pos_nxt = in_tuser ? ENT_AW'(1) : pos_r + ENT_AW'(1);
            end else begin
              // entry complete: judge it
              pos_nxt = '0;
              if (b0_r == DIR_END) begin
                stop_nxt = 1'b1;
              end else begin
                if (b0_r != DIR_FREE) begin
                  if (attr_r == ATTR_LFN) begin
                    if (b0_r[3:0] != 4'd0) begin
                      cp_k_nxt   = '0;
                      cp_wv_nxt  = 1'b0;
                      cp_ptr_nxt = LPTR_W'(LFN_CHARS) * LPTR_W'(b0_r[3:0] - 4'd1);
                      state_nxt  = S_LFN;
                    end
                  end else begin
                    use_long_nxt = pend_r;
                    first_nxt    = 1'b1;
                    idx_nxt      = '0;
                    lsize_nxt    = size_full;
                    lslot_nxt    = 4'(slot_r);
                    llist_nxt    = 4'(listed_r);
                    lfold_nxt    = attr_r[ATTR_DIR_B];
                    pend_nxt     = 1'b0;
                    listed_nxt   = listed_r + LIST_W'(1);
                    if ((listed_r + LIST_W'(1)) >= LIST_W'(MAX_LISTED)) begin
                      stop_nxt = 1'b1;
                    end
                    state_nxt = S_RD;
                  end
                end
                slot_nxt = slot_r + SLOT_W'(1);
                if ((slot_r + SLOT_W'(1)) >= SLOT_W'(ENTRIES_PER_SECTOR)) begin
                  stop_nxt = 1'b1;
                end
              end
            end
          end
        end
      end

      // copy 13 characters; each is registered out of the entry buffer, then written
      S_LFN: begin
        if (ln_wr.en && (cp_wptr_r == '0)) begin
          pend_nxt = (ent_rd_r != CHAR_NUL);
        end
        if (cp_k_r < 4'(LFN_CHARS)) begin
          cp_wv_nxt   = 1'b1;
          cp_wptr_nxt = cp_ptr_r;
          cp_ptr_nxt  = cp_ptr_r + LPTR_W'(1);
          cp_k_nxt    = cp_k_r + 4'd1;
        end else begin
          cp_wv_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      // memory read in flight
      S_RD: begin
        state_nxt = S_CAP;
      end

      // check the character just read
      S_CAP: begin
        if (first_r) begin
          first_nxt = 1'b0;
          if (term) begin
            cur_nxt   = CHAR_NUL;
            nterm_nxt = 1'b1;
            state_nxt = S_PUT;
          end else begin
            cur_nxt   = ch;
            idx_nxt   = idx_r + NIDX_W'(1);
            state_nxt = S_RD;
          end
        end else begin
          nch_nxt   = ch;
          nterm_nxt = term;
          state_nxt = S_PUT;
        end
      end

      // hand the current character to the output register
      S_PUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ochar_nxt = cur_r;
          olast_nxt = nterm_r;
          osize_nxt = lsize_r;
          oslot_nxt = lslot_r;
          olist_nxt = llist_r;
          ofold_nxt = lfold_r;
          if (nterm_r) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt   = nch_r;
            idx_nxt   = idx_r + NIDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pos_r    <= '0;
      slot_r   <= '0;
      listed_r <= '0;
      stop_r   <= 1'b0;
      pend_r   <= 1'b0;
      cp_wv_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      slot_r   <= slot_nxt;
      listed_r <= listed_nxt;
      stop_r   <= stop_nxt;
      pend_r   <= pend_nxt;
      cp_wv_r  <= cp_wv_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    b0_r       <= b0_nxt;
    attr_r     <= attr_nxt;
    size_r     <= size_nxt;
    cp_k_r     <= cp_k_nxt;
    cp_ptr_r   <= cp_ptr_nxt;
    cp_wptr_r  <= cp_wptr_nxt;
    use_long_r <= use_long_nxt;
    first_r    <= first_nxt;
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    nch_r      <= nch_nxt;
    nterm_r    <= nterm_nxt;
    lsize_r    <= lsize_nxt;
    lslot_r    <= lslot_nxt;
    llist_r    <= llist_nxt;
    lfold_r    <= lfold_nxt;
    ochar_r    <= ochar_nxt;
    olast_r    <= olast_nxt;
    osize_r    <= osize_nxt;
    oslot_r    <= oslot_nxt;
    olist_r    <= olist_nxt;
    ofold_r    <= ofold_nxt;
  end

  // Output word, held in the output register while the receiver stalls
  assign out_tvalid = ov_r;
  assign out_tdata  = {olist_r, oslot_r, osize_r, ochar_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = ofold_r;

endmodule

`default_nettype wire

[test/fdep_listing_checker.sv]
// ----------------------------------------------------------------------------
// fdep_listing_checker
// Watches both streams of the FAT directory entry parser. It keeps its own
// model of the sector scan and the long-name store, predicts the name words
// of every listed entry and compares each output word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module fdep_listing_checker
  import fdep_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] sector_start
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,  // [7:0] name_char, [39:8] size_bytes,
                                       // [43:40] entry_slot, [47:44] listing_index
  input  wire logic        out_tlast,  // last_char
  input  wire logic        out_tuser,  // [0] is_folder
  input  wire logic        end_check,
  output int               n_errors,
  output int               n_pending,
  output int               n_name_words
);
  timeunit 1ns;
  timeprecision 1ps;

  // Position of long-name character k inside a long-name record
  localparam logic [LFN_CHARS-1:0][4:0] CHAR_POS = {
    5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
    5'd14, 5'd9,  5'd7,  5'd5,  5'd3,  5'd1
  };

  typedef struct packed {
    logic [3:0]  lidx;
    logic [3:0]  slot;
    logic [31:0] size;
    logic        folder;
    logic        last;
    logic [7:0]  ch;
  } name_word_t;

  name_word_t  name_q[$];
  logic [7:0]  ent_buf [ENTRY_BYTES];
  logic [7:0]  lname   [LONG_NAME_BYTES];
  int unsigned byte_pos;
  int unsigned slot_cnt;
  int unsigned list_cnt;
  bit          stopped;
  bit          end_done;

  task automatic report_mismatch(input string msg);
    n_errors++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic restart_scan();
    byte_pos = 0;
    slot_cnt = 0;
    list_cnt = 0;
    stopped  = 1'b0;
    lname[0] = CHAR_NUL;
  endtask

  // Long-name record: scatter its 13 characters into the store
  task automatic store_long_chars();
    int unsigned ord;
    int unsigned at;
    ord = ent_buf[0][3:0];
    if (ord == 0) return;
    for (int k = 0; k < LFN_CHARS; k++) begin
      at = LFN_CHARS * (ord - 1) + k;
      if (at < LONG_NAME_BYTES) lname[at] = ent_buf[CHAR_POS[k]];
    end
  endtask

  // Listed entry: queue one name word per character
  task automatic queue_name_words();
    logic [7:0]  nm [NAME_CHARS];
    int          len;
    logic [31:0] size;
    logic        folder;
    name_word_t  w;
    len    = 0;
    size   = {ent_buf[31], ent_buf[30], ent_buf[29], ent_buf[28]};
    folder = ent_buf[POS_ATTR][ATTR_DIR_B];
    if (lname[0] != CHAR_NUL) begin
      while (len < NAME_CHARS && len < LONG_NAME_BYTES && lname[len] != CHAR_NUL) begin
        nm[len] = lname[len];
        len++;
      end
    end else begin
      while (len < SHORT_NAME_LEN && len < NAME_CHARS &&
             ent_buf[len] != CHAR_SPACE && ent_buf[len] != CHAR_NUL) begin
        nm[len] = ent_buf[len];
        len++;
      end
    end
    // empty name still gives one word
    if (len == 0) begin
      nm[0] = CHAR_NUL;
      len   = 1;
    end
    for (int k = 0; k < len; k++) begin
      w.ch     = nm[k];
      w.last   = (k == len - 1);
      w.size   = size;
      w.slot   = slot_cnt[3:0];
      w.folder = folder;
      w.lidx   = list_cnt[3:0];
      name_q.push_back(w);
    end
    list_cnt++;
    if (list_cnt >= MAX_LISTED) stopped = 1'b1;
    lname[0] = CHAR_NUL;
  endtask

  // One accepted sector byte
  task automatic take_sector_byte(input logic [7:0] d, input logic s);
    if (s) restart_scan();
    if (stopped) return;
    ent_buf[byte_pos] = d;
    if (byte_pos < ENTRY_BYTES - 1) begin
      byte_pos++;
      return;
    end
    byte_pos = 0;
    if (ent_buf[0] == DIR_END) begin
      stopped = 1'b1;
      return;
    end
    if (ent_buf[0] != DIR_FREE) begin
      if (ent_buf[POS_ATTR] == ATTR_LFN) store_long_chars();
      else queue_name_words();
    end
    slot_cnt++;
    if (slot_cnt >= ENTRIES_PER_SECTOR) stopped = 1'b1;
  endtask

  task automatic check_name_word();
    name_word_t exp;
    n_name_words++;
    if (name_q.size() == 0) begin
      report_mismatch($sformatf("unexpected name word char %02h last %0b",
                                out_tdata[7:0], out_tlast));
      return;
    end
    exp = name_q.pop_front();
    if (out_tdata[7:0] !== exp.ch || out_tlast !== exp.last ||
        out_tdata[39:8] !== exp.size || out_tdata[43:40] !== exp.slot ||
        out_tuser !== exp.folder || out_tdata[47:44] !== exp.lidx)
      report_mismatch($sformatf(
        "exp char %02h last %0b size %08h slot %0d dir %0b list %0d / got %02h %0b %08h %0d %0b %0d",
        exp.ch, exp.last, exp.size, exp.slot, exp.folder, exp.lidx,
        out_tdata[7:0], out_tlast, out_tdata[39:8], out_tdata[43:40], out_tuser,
        out_tdata[47:44]));
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_scan();
      for (int i = 0; i < LONG_NAME_BYTES; i++) lname[i] = CHAR_NUL;
      name_q.delete();
      n_errors     = 0;
      n_name_words = 0;
      end_done     = 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_name_word();
      if (in_tvalid && in_tready) take_sector_byte(in_tdata, in_tuser);
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (name_q.size() != 0)
          report_mismatch($sformatf("%0d expected name words never arrived", name_q.size()));
      end
    end
    n_pending <= name_q.size();
  end

endmodule

`default_nettype wire

[test/fat_directory_entry_parser_core_tb.sv]
// ----------------------------------------------------------------------------
// fat_directory_entry_parser_core_tb
// Drives directory sectors into the parser: a short directed sector with an
// empty name, a capped long name and scan end, then random entries mixed
// with noise. Both streams idle at random; a checker beside the block
// predicts and compares the name words.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_directory_entry_parser_core_tb
  import fdep_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 6;
  localparam int IDLE_PCT       = 19;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEM_TARGET    = 250;
  localparam int TAIL_CYCLES    = 3 * NAME_CHARS + 20;
  localparam int NO_ZERO        = 99;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  logic        calm       = 1'b0;   // no idling on either side
  logic        hold_req   = 1'b0;   // ask the receiver for one long hold-off
  logic        end_check  = 1'b0;

  int          n_errors;
  int          n_pending;
  int          n_name_words;
  int          words_sent   = 0;
  int          entries_sent = 0;
  int          sectors_sent = 0;
  int          idle_cycles  = 0;
  logic [7:0]  ent [ENTRY_BYTES];

  fat_directory_entry_parser_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  fdep_listing_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .end_check    (end_check),
    .n_errors     (n_errors),
    .n_pending    (n_pending),
    .n_name_words (n_name_words)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word accepted for %0d cycles", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Any byte but space and zero
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    c = 8'($urandom_range(254, 1));
    if (c >= CHAR_SPACE) c = c + 8'd1;
    return c;
  endfunction

  task automatic send_word(input logic [7:0] d, input logic s);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_entry(input bit new_sector);
    for (int i = 0; i < ENTRY_BYTES; i++) send_word(ent[i], new_sector && (i == 0));
    if (new_sector) sectors_sent++;
  endtask

  // Pause the sender until every expected name word has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  // Short entry: nlen name characters, then (if below 11) a space or zero terminator
  task automatic build_short(input int nlen, input logic folder, input logic [31:0] size);
    for (int i = 0; i < ENTRY_BYTES; i++) ent[i] = 8'($urandom);
    for (int i = 0; i < SHORT_NAME_LEN; i++) begin
      if (i < nlen) ent[i] = rand_char();
      else if (i == nlen) ent[i] = (nlen > 0 && $urandom_range(1)) ? CHAR_NUL : CHAR_SPACE;
    end
    if (ent[0] == DIR_FREE) ent[0] = 8'h46;
    ent[POS_ATTR][ATTR_DIR_B] = folder;
    if (ent[POS_ATTR] == ATTR_LFN) ent[POS_ATTR] = 8'h07;
    {ent[31], ent[30], ent[29], ent[28]} = size;
  endtask

  // Long-name record; character zero_at (if below 13) is a terminator
  task automatic build_long(input logic [7:0] ord, input int zero_at);
    for (int i = 0; i < ENTRY_BYTES; i++) ent[i] = 8'($urandom);
    ent[0]        = ord;
    ent[POS_ATTR] = ATTR_LFN;
    for (int k = 0; k < LFN_CHARS; k++)
      ent[lfn_offset(4'(k))] = (k == zero_at) ? CHAR_NUL : rand_char();
  endtask

  // Deleted entry or end-of-directory marker
  task automatic build_marker(input logic [7:0] first);
    for (int i = 0; i < ENTRY_BYTES; i++) ent[i] = 8'($urandom);
    ent[0] = first;
  endtask

  initial begin
    int         n_ent;
    int         kind;
    int         nrec;
    int         n_noise;
    bit         first;
    bit         noise;
    logic [7:0] ord;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sector: empty name first
    build_short(0, 1'b0, 32'h0);
    send_entry(1'b1);
    // three records fill the store past the name cap, no idling
    calm <= 1'b1;
    build_long(8'h43, NO_ZERO);
    send_entry(1'b0);
    build_long(8'h02, NO_ZERO);
    send_entry(1'b0);
    build_long(8'h01, NO_ZERO);
    send_entry(1'b0);
    calm <= 1'b0;
    // capped long name while the receiver holds off; input backs up
    hold_req <= 1'b1;
    build_short(SHORT_NAME_LEN, 1'b1, 32'hFFFF_FFFF);
    send_entry(1'b0);
    build_marker(DIR_END);
    send_entry(1'b0);
    wait_drained();

    // Random entries with some noise
    while (words_sent < ITEM_TARGET) begin
      n_ent = ($urandom_range(5) == 0) ? $urandom_range(18, 16) : $urandom_range(12, 1);
      first = 1'b1;
      for (int e = 0; e < n_ent && words_sent < ITEM_TARGET; e++) begin
        kind  = $urandom_range(99);
        noise = 1'b0;
        if (kind < 50) begin
          // listed entry, usually with a long name in front
          if ($urandom_range(9) < 6) begin
            nrec = $urandom_range(2, 1);
            for (int o = nrec; o >= 1; o--) begin
              build_long((o == nrec) ? (8'h40 | 8'(o)) : 8'(o), $urandom_range(40));
              send_entry(first);
              first = 1'b0;
            end
          end
          build_short($urandom_range(SHORT_NAME_LEN), 1'($urandom), 32'($urandom));
        end else if (kind < 62) begin
          // stray record, any ordinal
          ord = 8'($urandom);
          if (ord == DIR_END) ord = 8'h40;
          if (ord == DIR_FREE) ord = 8'h45;
          build_long(ord, $urandom_range(40));
        end else if (kind < 72) begin
          build_marker(DIR_FREE);
        end else if (kind < 76) begin
          build_marker(DIR_END);
        end else if (kind < 86) begin
          build_short($urandom_range(SHORT_NAME_LEN), 1'($urandom), 32'($urandom));
        end else begin
          // loose bytes, now and then a sector start mid-entry
          noise   = 1'b1;
          n_noise = $urandom_range(40, 1);
          for (int i = 0; i < n_noise; i++) begin
            send_word(8'($urandom), first || ($urandom_range(15) == 0));
            first = 1'b0;
          end
        end
        if (!noise) begin
          send_entry(first);
          first = 1'b0;
        end
        entries_sent++;
      end
      if ($urandom_range(3) == 0) wait_drained();
    end

    // Drain and let any stray word show up
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Run covered %0d sector words in %0d sectors (%0d random entries).",
             words_sent, sectors_sent, entries_sent);
    $display("Name words compared: %0d, mismatches: %0d.", n_name_words, n_errors);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
sv/fdep_pkg.sv
sv/fdep_name_store.sv
sv/fat_directory_entry_parser_core.sv
test/fdep_listing_checker.sv
test/fat_directory_entry_parser_core_tb.sv
